>>> design/clifford_move_canonicalize_defines.svh
// Assertion helpers for the move/canonicalize block.
`ifndef CLIFFORD_MOVE_CANONICALIZE_DEFINES_SVH
`define CLIFFORD_MOVE_CANONICALIZE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CMC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cmc: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define CMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cmc: next-cycle check failed");

`endif

>>> design/cmc_pkg.sv
`default_nettype none
package cmc_pkg;

    localparam int unsigned QUBIT_COUNT = 4;
    localparam int unsigned QUBIT_SPAN  = 16;
    localparam int unsigned COLUMN_SPAN = 8;
    localparam int unsigned STATE_W     = QUBIT_COUNT * QUBIT_SPAN;
    localparam int unsigned FRAME_W     = QUBIT_COUNT * 4;

    // Axis codes; the unused code acts as Y.
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Z = 2'd1;
    localparam logic [1:0] AXIS_Y = 2'd2;

    // Frame codes for each kept value.
    localparam logic [1:0] FRAME_X  = 2'd1;
    localparam logic [1:0] FRAME_Z  = 2'd2;
    localparam logic [1:0] FRAME_XZ = 2'd3;

    typedef logic [7:0] col_t;

    typedef struct packed {
        logic [1:0] qubit_one;
        logic [1:0] qubit_two;
        logic [1:0] axis_one;
        logic [1:0] axis_two;
    } move_t;

endpackage
`default_nettype wire

>>> design/cmc_step.sv
`default_nettype none
module cmc_step (
    input  wire logic [cmc_pkg::STATE_W-1:0] tableau_state,
    input  wire cmc_pkg::move_t              move_a,
    input  wire logic                        move_b_enable,
    input  wire cmc_pkg::move_t              move_b,
    output logic [cmc_pkg::STATE_W-1:0]      canonical_state,
    output logic [cmc_pkg::FRAME_W-1:0]      frame_codes
);
    import cmc_pkg::*;

    // Byte column of qubit q: X when zpart is 0, Z when 1.
    function automatic col_t get_col(logic [STATE_W-1:0] st, logic [1:0] q,
                                     logic zpart);
        return st[{q, zpart, 3'b000} +: COLUMN_SPAN];
    endfunction

    // One Pauli-product rotation; both anti terms come from the old state.
    function automatic logic [STATE_W-1:0] rotate(logic [STATE_W-1:0] st,
                                                  move_t mv);
        logic       fx, fz, sx, sz;
        col_t       af, as_col;
        logic [1:0] qi;
        logic [STATE_W-1:0] res;
        fx = (mv.axis_one != AXIS_Z);
        fz = (mv.axis_one != AXIS_X);
        sx = (mv.axis_two != AXIS_Z);
        sz = (mv.axis_two != AXIS_X);
        af = (fx ? get_col(st, mv.qubit_one, 1'b1) : '0)
           ^ (fz ? get_col(st, mv.qubit_one, 1'b0) : '0);
        as_col = (sx ? get_col(st, mv.qubit_two, 1'b1) : '0)
               ^ (sz ? get_col(st, mv.qubit_two, 1'b0) : '0);
        res = st;
        for (int i = 0; i < QUBIT_COUNT; i++) begin
            qi = 2'(i);
            res[i*QUBIT_SPAN +: COLUMN_SPAN] = res[i*QUBIT_SPAN +: COLUMN_SPAN]
                ^ ((fx && mv.qubit_one == qi) ? as_col : '0)
                ^ ((sx && mv.qubit_two == qi) ? af : '0);
            res[i*QUBIT_SPAN+COLUMN_SPAN +: COLUMN_SPAN] =
                res[i*QUBIT_SPAN+COLUMN_SPAN +: COLUMN_SPAN]
                ^ ((fz && mv.qubit_one == qi) ? as_col : '0)
                ^ ((sz && mv.qubit_two == qi) ? af : '0);
        end
        return res;
    endfunction

    // Tie order: X first, then Z, then X^Z.
    function automatic logic [1:0] which_value(col_t v, col_t x, col_t z);
        priority if (v == x) return FRAME_X;
        else if (v == z)     return FRAME_Z;
        else                 return FRAME_XZ;
    endfunction

    logic [STATE_W-1:0] after_a;
    logic [STATE_W-1:0] after_b;

    // Moves applied in order.
    always_comb
    begin
        after_a = rotate(tableau_state, move_a);
        after_b = move_b_enable ? rotate(after_a, move_b) : after_a;
    end

    // Per-qubit three-value sort, keep the two smallest.
    always_comb
    begin
        col_t x, z, y, a, b, c, t;
        canonical_state = '0;
        frame_codes     = '0;
        t               = '0;
        for (int q = 0; q < QUBIT_COUNT; q++) begin
            x = after_b[q*QUBIT_SPAN +: COLUMN_SPAN];
            z = after_b[q*QUBIT_SPAN+COLUMN_SPAN +: COLUMN_SPAN];
            y = x ^ z;
            a = x;
            b = z;
            c = y;
            if (a > b) begin t = a; a = b; b = t; end
            if (b > c) begin t = b; b = c; c = t; end
            if (a > b) begin t = a; a = b; b = t; end
            canonical_state[q*QUBIT_SPAN +: COLUMN_SPAN]             = a;
            canonical_state[q*QUBIT_SPAN+COLUMN_SPAN +: COLUMN_SPAN] = b;
            frame_codes[q*4 +: 4] = {which_value(b, x, z), which_value(a, x, z)};
        end
    end

endmodule
`default_nettype wire

>>> design/clifford_move_canonicalize.sv
// Path: input register, then the move and sort logic, then the result register.
// Throughput: one beat per cycle while out_ready does not stall the result register.
// The result register decouples the sides, so a stalled result still lets one beat in.
// Reset (rst_n, asynchronous, active low) clears both valid flags; nothing else is kept.
`default_nettype none
`include "clifford_move_canonicalize_defines.svh"
module clifford_move_canonicalize (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [cmc_pkg::STATE_W-1:0] tableau_state,
    input  wire logic [1:0]                  move_a_qubit_one,
    input  wire logic [1:0]                  move_a_qubit_two,
    input  wire logic [1:0]                  move_a_axis_one,
    input  wire logic [1:0]                  move_a_axis_two,
    input  wire logic                        move_b_enable,
    input  wire logic [1:0]                  move_b_qubit_one,
    input  wire logic [1:0]                  move_b_qubit_two,
    input  wire logic [1:0]                  move_b_axis_one,
    input  wire logic [1:0]                  move_b_axis_two,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [cmc_pkg::STATE_W-1:0]      canonical_state,
    output logic [cmc_pkg::FRAME_W-1:0]      frame_codes
);
    import cmc_pkg::*;

    logic               in_valid_reg;
    logic [STATE_W-1:0] state_reg;
    move_t              move_a_reg;
    move_t              move_b_reg;
    logic               b_enable_reg;
    logic               out_valid_reg;
    logic [STATE_W-1:0] canon_reg;
    logic [FRAME_W-1:0] frame_reg;

    logic               advance;
    logic               accept;
    logic [STATE_W-1:0] canon_next;
    logic [FRAME_W-1:0] frame_next;

    // Handshake: result slot frees when empty or taken.
    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg || advance;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign canonical_state = canon_reg;
    assign frame_codes     = frame_reg;

    cmc_step u_step (
        .tableau_state   (state_reg),
        .move_a          (move_a_reg),
        .move_b_enable   (b_enable_reg),
        .move_b          (move_b_reg),
        .canonical_state (canon_next),
        .frame_codes     (frame_next)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    // Input beat capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            state_reg    <= tableau_state;
            move_a_reg   <= '{qubit_one: move_a_qubit_one, qubit_two: move_a_qubit_two,
                              axis_one: move_a_axis_one, axis_two: move_a_axis_two};
            b_enable_reg <= move_b_enable;
            move_b_reg   <= '{qubit_one: move_b_qubit_one, qubit_two: move_b_qubit_two,
                              axis_one: move_b_axis_one, axis_two: move_b_axis_two};
        end
    end

    // Result capture
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            canon_reg <= canon_next;
            frame_reg <= frame_next;
        end
    end

    // Checks
    `CMC_ASSERT_NEXT(a_accept_loads, clk, rst_n, accept, in_valid_reg)
    `CMC_ASSERT_NEXT(a_stage_moves, clk, rst_n, in_valid_reg && advance, out_valid_reg)
    `CMC_ASSERT_IMPL(a_full_blocks, clk, rst_n, in_valid_reg && !advance, !in_ready)
    `CMC_ASSERT_IMPL(a_sorted_q0, clk, rst_n, out_valid_reg,
        canon_reg[COLUMN_SPAN-1:0] <= canon_reg[QUBIT_SPAN-1:COLUMN_SPAN]
        && frame_reg[1:0] != 2'd0 && frame_reg[3:2] != 2'd0)

endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import cmc_pkg::*;

    // Axis code 3 is unused by the encoding but behaves as Y
    localparam logic [1:0] AXIS_ALT = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_PER_PHASE = 450;
    localparam int unsigned DRAIN_CYCLES = 10;
    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct {
        logic [STATE_W-1:0] tableau;
        move_t              first;
        logic               second_en;
        move_t              second;
    } move_beat_t;

    typedef struct {
        logic [STATE_W-1:0] canon;
        logic [FRAME_W-1:0] frames;
    } canon_result_t;

    // Expected canonical forms, in beat order
    class canon_scoreboard;
        canon_result_t pending_q[$];
        int unsigned   errors;

        function new();
            errors = 0;
        endfunction

        // One Pauli-product rotation; both anti values come from the old state
        function logic [STATE_W-1:0] rotate(logic [STATE_W-1:0] st, move_t m);
            logic        fx, fz, sx, sz;
            col_t        anti_f, anti_s;
            int unsigned fb, sb;
            fx = (m.axis_one != AXIS_Z);
            fz = (m.axis_one != AXIS_X);
            sx = (m.axis_two != AXIS_Z);
            sz = (m.axis_two != AXIS_X);
            fb = m.qubit_one * QUBIT_SPAN;
            sb = m.qubit_two * QUBIT_SPAN;
            anti_f = (fx ? st[fb + COLUMN_SPAN +: 8] : 8'h00) ^ (fz ? st[fb +: 8] : 8'h00);
            anti_s = (sx ? st[sb + COLUMN_SPAN +: 8] : 8'h00) ^ (sz ? st[sb +: 8] : 8'h00);
            if (fx) st[fb +: 8] = st[fb +: 8] ^ anti_s;
            if (fz) st[fb + COLUMN_SPAN +: 8] = st[fb + COLUMN_SPAN +: 8] ^ anti_s;
            if (sx) st[sb +: 8] = st[sb +: 8] ^ anti_f;
            if (sz) st[sb + COLUMN_SPAN +: 8] = st[sb + COLUMN_SPAN +: 8] ^ anti_f;
            return st;
        endfunction

        // Ties resolve to the first match in X, Z, X^Z order
        function logic [1:0] frame_of(col_t v, col_t xc, col_t zc);
            if (v == xc) return FRAME_X;
            if (v == zc) return FRAME_Z;
            return FRAME_XZ;
        endfunction

        function canon_result_t canonicalize(move_beat_t b);
            logic [STATE_W-1:0] st;
            canon_result_t      r;
            col_t               xc, zc, lo, mid, hi, t;
            st = rotate(b.tableau, b.first);
            if (b.second_en) st = rotate(st, b.second);
            r.canon  = '0;
            r.frames = '0;
            for (int q = 0; q < QUBIT_COUNT; q++)
            begin
                xc  = st[q * QUBIT_SPAN +: 8];
                zc  = st[q * QUBIT_SPAN + COLUMN_SPAN +: 8];
                lo  = xc;
                mid = zc;
                hi  = xc ^ zc;
                if (lo > mid) begin t = lo; lo = mid; mid = t; end
                if (mid > hi) begin t = mid; mid = hi; hi = t; end
                if (lo > mid) begin t = lo; lo = mid; mid = t; end
                r.canon[q * QUBIT_SPAN +: 8]               = lo;
                r.canon[q * QUBIT_SPAN + COLUMN_SPAN +: 8] = mid;
                r.frames[q * 4 +: 4] = {frame_of(mid, xc, zc), frame_of(lo, xc, zc)};
            end
            return r;
        endfunction

        function void note_input(move_beat_t b);
            pending_q = {pending_q, canonicalize(b)};
        endfunction

        function void check_result(logic [STATE_W-1:0] canon, logic [FRAME_W-1:0] frames);
            canon_result_t want;
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: unexpected result beat canon=%h frames=%h",
                             $realtime, canon, frames);
                return;
            end
            want = pending_q.pop_front();
            if (canon !== want.canon || frames !== want.frames)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: mismatch canon exp=%h got=%h frames exp=%h got=%h",
                             $realtime, want.canon, canon, want.frames, frames);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [STATE_W-1:0] tableau_state = '0;
    logic [1:0] move_a_qubit_one = '0;
    logic [1:0] move_a_qubit_two = '0;
    logic [1:0] move_a_axis_one = '0;
    logic [1:0] move_a_axis_two = '0;
    logic move_b_enable = 1'b0;
    logic [1:0] move_b_qubit_one = '0;
    logic [1:0] move_b_qubit_two = '0;
    logic [1:0] move_b_axis_one = '0;
    logic [1:0] move_b_axis_two = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [STATE_W-1:0] canonical_state;
    logic [FRAME_W-1:0] frame_codes;

    int unsigned send_idle_pct = 26;
    int unsigned recv_idle_pct = 51;
    int unsigned cycle_count = 0;
    canon_scoreboard sb;
    logic [1:0] axis_codes [4] = '{AXIS_X, AXIS_Z, AXIS_Y, AXIS_ALT};

    clifford_move_canonicalize u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .tableau_state    (tableau_state),
        .move_a_qubit_one (move_a_qubit_one),
        .move_a_qubit_two (move_a_qubit_two),
        .move_a_axis_one  (move_a_axis_one),
        .move_a_axis_two  (move_a_axis_two),
        .move_b_enable    (move_b_enable),
        .move_b_qubit_one (move_b_qubit_one),
        .move_b_qubit_two (move_b_qubit_two),
        .move_b_axis_one  (move_b_axis_one),
        .move_b_axis_two  (move_b_axis_two),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .canonical_state  (canonical_state),
        .frame_codes      (frame_codes)
    );

    always #5 clk = ~clk;

    // Hard stop in case a beat never gets through
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: check accepted beats, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(canonical_state, frame_codes);
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic logic [1:0] pick_axis();
        if ($urandom_range(0, 9) == 0) return AXIS_ALT;
        return axis_codes[$urandom_range(0, 2)];
    endfunction

    function automatic move_t pick_move();
        move_t m;
        m.qubit_one = 2'($urandom_range(0, 3));
        m.qubit_two = 2'($urandom_range(0, 3));
        m.axis_one  = pick_axis();
        m.axis_two  = pick_axis();
        return m;
    endfunction

    // Mostly random columns, with some qubits shaped to force sort ties
    function automatic logic [STATE_W-1:0] pick_tableau();
        logic [STATE_W-1:0] st;
        col_t xc, zc;
        for (int q = 0; q < QUBIT_COUNT; q++)
        begin
            xc = 8'($urandom);
            zc = 8'($urandom);
            case ($urandom_range(0, 9))
                0: zc = xc;
                1: xc = 8'h00;
                2: zc = 8'h00;
                3: begin xc = 8'h00; zc = 8'h00; end
                4: begin xc = 8'hff; zc = 8'($urandom_range(0, 1) ? 8'hff : 8'h00); end
                default: ;
            endcase
            st[q * QUBIT_SPAN +: 8]               = xc;
            st[q * QUBIT_SPAN + COLUMN_SPAN +: 8] = zc;
        end
        return st;
    endfunction

    function automatic move_t make_move(int f, int s, logic [1:0] axf, logic [1:0] axs);
        move_t m;
        m.qubit_one = 2'(f);
        m.qubit_two = 2'(s);
        m.axis_one  = axf;
        m.axis_two  = axs;
        return m;
    endfunction

    function automatic move_beat_t make_beat(logic [STATE_W-1:0] st, move_t ma,
                                             logic en, move_t mb);
        move_beat_t b;
        b.tableau   = st;
        b.first     = ma;
        b.second_en = en;
        b.second    = mb;
        return b;
    endfunction

    // Drive one input beat and hold it until the block takes it
    task automatic send_beat(input move_beat_t b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid         <= 1'b1;
        tableau_state    <= b.tableau;
        move_a_qubit_one <= b.first.qubit_one;
        move_a_qubit_two <= b.first.qubit_two;
        move_a_axis_one  <= b.first.axis_one;
        move_a_axis_two  <= b.first.axis_two;
        move_b_enable    <= b.second_en;
        move_b_qubit_one <= b.second.qubit_one;
        move_b_qubit_two <= b.second.qubit_two;
        move_b_axis_one  <= b.second.axis_one;
        move_b_axis_two  <= b.second.axis_two;
        do @(posedge clk); while (!in_ready);
        sb.note_input(b);
    endtask

    task automatic run_directed();
        logic [STATE_W-1:0] ties_equal, ties_zero_x;
        move_t ones_move;
        ones_move = make_move(3, 3, AXIS_ALT, AXIS_ALT);
        // Column extremes
        send_beat(make_beat('0, make_move(0, 1, AXIS_X, AXIS_X), 1'b0, ones_move));
        send_beat(make_beat('1, make_move(3, 2, AXIS_Y, AXIS_Y), 1'b1,
                            make_move(0, 0, AXIS_ALT, AXIS_Y)));
        // Every axis pair on the first move
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                send_beat(make_beat(pick_tableau(), make_move(i, (i + j + 1) % 4,
                                    axis_codes[i], axis_codes[j]), 1'b0, make_move(0, 0,
                                    AXIS_X, AXIS_X)));
        // Same qubit on both sides
        send_beat(make_beat(64'h0123_4567_89ab_cdef, make_move(2, 2, AXIS_Y, AXIS_X),
                            1'b1, make_move(1, 1, AXIS_Z, AXIS_ALT)));
        // X equals Z on every qubit; Y-Y moves leave that tie in place
        ties_equal = 64'h5a5a_0f0f_c3c3_8181;
        send_beat(make_beat(ties_equal, make_move(0, 1, AXIS_Y, AXIS_Y), 1'b1,
                            make_move(2, 3, AXIS_Y, AXIS_ALT)));
        // X zero: Z and X^Z tie; Z-Z moves see no anticommutation
        ties_zero_x = 64'h3c00_ff00_0100_8000;
        send_beat(make_beat(ties_zero_x, make_move(1, 3, AXIS_Z, AXIS_Z), 1'b1,
                            make_move(0, 2, AXIS_Z, AXIS_Z)));
        // Second move fields all ones, disabled then enabled
        send_beat(make_beat(64'hfedc_ba98_7654_3210, make_move(0, 3, AXIS_X, AXIS_Z),
                            1'b0, ones_move));
        send_beat(make_beat(64'hfedc_ba98_7654_3210, make_move(0, 3, AXIS_X, AXIS_Z),
                            1'b1, ones_move));
    endtask

    task automatic run_random(int unsigned count);
        for (int unsigned n = 0; n < count; n++)
            send_beat(make_beat(pick_tableau(), pick_move(), 1'($urandom_range(0, 1)),
                                pick_move()));
    endtask

    initial
    begin
        // Scheduled so the falling edge reaches the asynchronous reset
        rst_n <= 1'b0;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random(RANDOM_PER_PHASE);

        send_idle_pct = 51;
        recv_idle_pct = 26;
        run_random(RANDOM_PER_PHASE);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_PER_PHASE);
        in_valid <= 1'b0;

        // Drain outstanding results, then allow a few more cycles for strays
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
